>>> src/csmv_pkg.sv
// Shared types and constants for the CSR sparse matrix-vector multiply block.
// No dependencies; every other file except csmv_queue refers to it by scoped names.
package csmv_pkg;

  localparam int INDEX_W    = 12;
  localparam int VALUE_W    = 32;
  localparam int ROW_W      = 20;
  localparam int CUR_ROW_W  = 21;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;
  localparam int ACC_W      = 64;

  // Queue depths (powers of two)
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_ROW = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END_ROW   = 1'b1;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_LOAD    = 2'd1,
    OP_NONZERO = 2'd2,
    OP_EMPTY   = 2'd3
  } op_t;

  // Request passed from the front to the back
  typedef struct packed {
    op_t                       op;
    logic [INDEX_W-1:0]        index;
    logic signed [VALUE_W-1:0] value;
    logic                      emit;
    logic [ROW_W-1:0]          row;
    logic                      last;
  } mid_item_t;

  // Row result waiting on the output side
  typedef struct packed {
    logic signed [VALUE_W-1:0] y_value;
    logic [ROW_W-1:0]          row_index;
    logic                      last_row;
  } out_item_t;

endpackage

>>> src/csmv_queue.sv
// Small register queue of packed words, power-of-two depth.
// Used between front and back and on the result side; no package use.
module csmv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH):0]     count
);

  localparam int PTR_W = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r;
  logic [PTR_W-1:0] rptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push;
  logic             do_pop;

  assign empty   = (count_r == '0);
  assign count   = count_r;
  assign rdata   = mem_r[rptr_r];
  assign do_pop  = pop && !empty;
  assign do_push = push && (count_r != (PTR_W+1)'(DEPTH));

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Store pushed word
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= wdata;
  end

endmodule

>>> src/csmv_front.sv
// Front end: configuration registers, row tracking and request classification.
// Depends on csmv_pkg; feeds the middle queue.
module csmv_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [csmv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csmv_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_push,
  input  logic [1:0]                          in_opcode,
  input  logic [csmv_pkg::INDEX_W-1:0]        in_index,
  input  logic signed [csmv_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_row_end,
  input  logic                                q_full,
  output logic                                q_push,
  output csmv_pkg::mid_item_t                 q_item
);

  logic [csmv_pkg::ROW_W-1:0]     first_row_r;
  logic [csmv_pkg::CUR_ROW_W-1:0] end_row_r;
  logic [csmv_pkg::CUR_ROW_W-1:0] cur_row_r;
  logic [csmv_pkg::CUR_ROW_W-1:0] cur_row_nxt;
  logic [csmv_pkg::CUR_ROW_W-1:0] row_inc;
  csmv_pkg::op_t                  op;
  logic                           accept;
  logic                           active;
  logic                           keep;
  logic                           emit;

  assign op      = csmv_pkg::op_t'(in_opcode);
  assign accept  = in_push && !q_full;
  assign active  = cur_row_r < end_row_r;
  assign row_inc = cur_row_r + 1'b1;

  // Classify request; drop row requests outside the batch
  always_comb begin
    keep        = 1'b0;
    emit        = 1'b0;
    cur_row_nxt = cur_row_r;
    unique case (op)
      csmv_pkg::OP_START: begin
        keep        = 1'b1;
        cur_row_nxt = {1'b0, first_row_r};
      end
      csmv_pkg::OP_LOAD: begin
        keep = 1'b1;
      end
      csmv_pkg::OP_NONZERO: begin
        keep = active;
        emit = active && in_row_end;
      end
      csmv_pkg::OP_EMPTY: begin
        keep = active;
        emit = active;
      end
    endcase
    if (emit) cur_row_nxt = row_inc;
  end

  assign q_push       = accept && keep;
  assign q_item.op    = op;
  assign q_item.index = in_index;
  assign q_item.value = in_value;
  assign q_item.emit  = emit;
  assign q_item.row   = cur_row_r[csmv_pkg::ROW_W-1:0];
  assign q_item.last  = (row_inc == end_row_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_row_r <= '0;
      end_row_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csmv_pkg::CFG_FIRST_ROW: first_row_r <= cfg_data[csmv_pkg::ROW_W-1:0];
        csmv_pkg::CFG_END_ROW:   end_row_r   <= cfg_data;
      endcase
    end
  end

  // Advance current row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
    end else if (accept) begin
      cur_row_r <= cur_row_nxt;
    end
  end

endmodule

>>> src/csmv_back.sv
// Back end: x vector store, multiply-accumulate pipeline, saturation, result queue.
// Depends on csmv_pkg and csmv_queue.
module csmv_back #(
  parameter int MAX_COLUMNS = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 mid_empty,
  input  csmv_pkg::mid_item_t                  mid_item,
  output logic                                 mid_pop,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [csmv_pkg::VALUE_W-1:0]  out_y_value,
  output logic [csmv_pkg::ROW_W-1:0]           out_row_index,
  output logic                                 out_last_row
);

  localparam int FULL_DEPTH = 2 ** csmv_pkg::INDEX_W;
  localparam int DEPTH      = (MAX_COLUMNS < FULL_DEPTH) ? MAX_COLUMNS : FULL_DEPTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(csmv_pkg::OUT_DEPTH) + 1;
  localparam int VW         = csmv_pkg::VALUE_W;
  localparam int AW         = csmv_pkg::ACC_W;

  // x vector store
  logic [VW-1:0] xmem_r [DEPTH];

  logic                      in_range;
  logic [ADDR_W-1:0]         addr;
  logic                      issue;
  logic [CNT_W-1:0]          out_count;
  logic [CNT_W-1:0]          inflight;

  logic                      s1_valid_r;
  csmv_pkg::mid_item_t       s1_item_r;
  logic                      s1_in_range_r;
  logic signed [VW-1:0]      x_rd_r;
  logic signed [VW-1:0]      x_eff;

  logic                      s2_valid_r;
  csmv_pkg::op_t             s2_op_r;
  logic                      s2_emit_r;
  logic [csmv_pkg::ROW_W-1:0] s2_row_r;
  logic                      s2_last_r;
  logic signed [AW-1:0]      s2_prod_r;

  logic                      s3_valid_r;
  logic signed [AW-1:0]      s3_sum_r;
  logic [csmv_pkg::ROW_W-1:0] s3_row_r;
  logic                      s3_last_r;

  logic signed [AW-1:0]      acc_r;
  logic signed [AW-1:0]      acc_nxt;
  logic signed [AW-1:0]      shifted;
  logic signed [AW-1:0]      sum;
  logic signed [AW-1:0]      row_result;
  logic                      s3_load;

  csmv_pkg::out_item_t       push_item;
  csmv_pkg::out_item_t       head_item;

  assign in_range = ({{(32 - csmv_pkg::INDEX_W){1'b0}}, mid_item.index} < 32'(DEPTH));
  assign addr     = mid_item.index[ADDR_W-1:0];

  // Issue only with room reserved for every result still in flight
  assign inflight = CNT_W'(s1_valid_r && s1_item_r.emit)
                  + CNT_W'(s2_valid_r && s2_emit_r)
                  + CNT_W'(s3_valid_r);
  assign issue    = !mid_empty && ((out_count + inflight) < CNT_W'(csmv_pkg::OUT_DEPTH));
  assign mid_pop  = issue;

  // Stage 1: write or read the x store
  always_ff @(posedge clk) begin
    if (issue && (mid_item.op == csmv_pkg::OP_LOAD) && in_range) begin
      xmem_r[addr] <= mid_item.value;
    end
    x_rd_r <= xmem_r[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_item_r     <= mid_item;
      s1_in_range_r <= in_range;
    end
  end

  // Stage 2: multiply value by x
  assign x_eff = s1_in_range_r ? x_rd_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r   <= s1_item_r.op;
    s2_emit_r <= s1_item_r.emit;
    s2_row_r  <= s1_item_r.row;
    s2_last_r <= s1_item_r.last;
    s2_prod_r <= s1_item_r.value * x_eff;
  end

  // Stage 3: scale product and accumulate the row
  assign shifted = s2_prod_r >>> FRAC_BITS;
  assign sum     = acc_r + shifted;
  assign s3_load = s2_valid_r && s2_emit_r;

  always_comb begin
    acc_nxt    = acc_r;
    row_result = sum;
    if (s2_valid_r) begin
      unique case (s2_op_r)
        csmv_pkg::OP_START:   acc_nxt = '0;
        csmv_pkg::OP_LOAD:    acc_nxt = acc_r;
        csmv_pkg::OP_NONZERO: acc_nxt = s2_emit_r ? '0 : sum;
        csmv_pkg::OP_EMPTY: begin
          acc_nxt    = '0;
          row_result = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      s3_valid_r <= 1'b0;
    end else begin
      acc_r      <= acc_nxt;
      s3_valid_r <= s3_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      s3_sum_r  <= row_result;
      s3_row_r  <= s2_row_r;
      s3_last_r <= s2_last_r;
    end
  end

  // Stage 4: saturate to 32 bits and queue the result
  always_comb begin
    if ((s3_sum_r[AW-1:VW-1] == '0) || (s3_sum_r[AW-1:VW-1] == '1)) begin
      push_item.y_value = s3_sum_r[VW-1:0];
    end else if (s3_sum_r[AW-1]) begin
      push_item.y_value = {1'b1, {(VW-1){1'b0}}};
    end else begin
      push_item.y_value = {1'b0, {(VW-1){1'b1}}};
    end
    push_item.row_index = s3_row_r;
    push_item.last_row  = s3_last_r;
  end

  csmv_queue #(
    .WIDTH ($bits(csmv_pkg::out_item_t)),
    .DEPTH (csmv_pkg::OUT_DEPTH)
  ) u_out_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s3_valid_r),
    .wdata (push_item),
    .pop   (out_pop),
    .rdata (head_item),
    .empty (out_empty),
    .count (out_count)
  );

  assign out_y_value   = head_item.y_value;
  assign out_row_index = head_item.row_index;
  assign out_last_row  = head_item.last_row;

  // Result queue never receives a request while full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> (out_count < CNT_W'(csmv_pkg::OUT_DEPTH)))
    else $error("result queue overflow");

  // Reserved slots never exceed the queue depth
  a_credit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_count + inflight) <= CNT_W'(csmv_pkg::OUT_DEPTH))
    else $error("result credit exceeded");

  // Row sum restarts after every emitted row
  a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s3_load |=> (acc_r == '0))
    else $error("row sum not cleared after row result");

  // A result in stage 3 comes from an emitting request in stage 2
  a_emit_origin: assert property (@(posedge clk) disable iff (!rst_n)
    s3_valid_r |-> $past(s2_valid_r && s2_emit_r))
    else $error("row result without source request");

endmodule

>>> src/csr_sparse_matrix_vector_multiply.sv
// CSR sparse matrix-vector multiply, Q16.16, with a front classifier and a MAC back end.
// A row-ending request's result passes the middle queue, back stages 1-3 and result queue.
// Throughput: one request per cycle if result credit allows; one x read, one MAC stage.
// Reset (synchronous, rst_n low) clears queues, row tracking, configuration and the row sum.
// The x store is not cleared; entries are valid only once loaded. Uses csmv_pkg.
module csr_sparse_matrix_vector_multiply #(
  parameter int MAX_COLUMNS = 4096,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [csmv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [csmv_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_push,
  output logic                                 in_full,
  input  logic [1:0]                           in_opcode,
  input  logic [csmv_pkg::INDEX_W-1:0]         in_index,
  input  logic signed [csmv_pkg::VALUE_W-1:0]  in_value,
  input  logic                                 in_row_end,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic signed [csmv_pkg::VALUE_W-1:0]  out_y_value,
  output logic [csmv_pkg::ROW_W-1:0]           out_row_index,
  output logic                                 out_last_row
);

  localparam int MID_CNT_W = $clog2(csmv_pkg::MID_DEPTH) + 1;

  logic                    q_push;
  csmv_pkg::mid_item_t     q_item;
  csmv_pkg::mid_item_t     mid_item;
  logic                    mid_empty;
  logic                    mid_pop;
  logic [MID_CNT_W-1:0]    mid_count;

  assign in_full = (mid_count == MID_CNT_W'(csmv_pkg::MID_DEPTH));

  csmv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_push    (in_push),
    .in_opcode  (in_opcode),
    .in_index   (in_index),
    .in_value   (in_value),
    .in_row_end (in_row_end),
    .q_full     (in_full),
    .q_push     (q_push),
    .q_item     (q_item)
  );

  csmv_queue #(
    .WIDTH ($bits(csmv_pkg::mid_item_t)),
    .DEPTH (csmv_pkg::MID_DEPTH)
  ) u_mid_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_item),
    .pop   (mid_pop),
    .rdata (mid_item),
    .empty (mid_empty),
    .count (mid_count)
  );

  csmv_back #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .mid_empty     (mid_empty),
    .mid_item      (mid_item),
    .mid_pop       (mid_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_y_value   (out_y_value),
    .out_row_index (out_row_index),
    .out_last_row  (out_last_row)
  );

endmodule
